/* rtl/nbt_pkg.sv */
// ----------------------------------------------------------------------------
// nbt_pkg
// Shared types, job codes and character helpers for the node-status decoder.
// ----------------------------------------------------------------------------
package nbt_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_NAMES = 2'd1;
  localparam logic [1:0] PH_MAC   = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [2:0] K_NONE    = 3'd0;
  localparam logic [2:0] K_CHAR    = 3'd1;
  localparam logic [2:0] K_HEX     = 3'd2;
  localparam logic [2:0] K_SUFFIX  = 3'd3;
  localparam logic [2:0] K_MAC_SEP = 3'd4;
  localparam logic [2:0] K_MAC_END = 3'd5;
  localparam logic [2:0] K_BARE    = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else begin
      ch = CH_A + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

  function automatic logic [2:0] job_len(input logic [2:0] kind);
    logic [2:0] n;
    case (kind)
      K_HEX:     n = 3'd4;
      K_SUFFIX:  n = 3'd5;
      K_MAC_SEP: n = 3'd3;
      K_MAC_END: n = 3'd2;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] job_char(input logic [2:0] kind, input logic [7:0] data,
                                          input logic [2:0] idx);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] ch;
    hi = hex_digit(data[7:4]);
    lo = hex_digit(data[3:0]);
    case (kind)
      K_CHAR: ch = data;
      K_HEX, K_SUFFIX: begin
        case (idx)
          3'd0:    ch = CH_LT;
          3'd1:    ch = hi;
          3'd2:    ch = lo;
          3'd3:    ch = CH_GT;
          default: ch = CH_NL;
        endcase
      end
      K_MAC_SEP, K_MAC_END: begin
        case (idx)
          3'd0:    ch = hi;
          3'd1:    ch = lo;
          default: ch = CH_DASH;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/nbt_front.sv */
// ----------------------------------------------------------------------------
// nbt_front
// Accepts record bytes, tracks the decode state and queues at most one job per byte.
// ----------------------------------------------------------------------------
module nbt_front #(
  parameter int NAME_CHARS  = 15,
  parameter int ENTRY_BYTES = 18,
  parameter int MAC_BYTES   = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_record_start,
  input  logic              in_record_last,
  input  logic [15:0]       in_record_length,
  input  logic              q_full,
  output logic              push,
  output nbt_pkg::job_t     push_job
);

  localparam int EPW = $clog2(ENTRY_BYTES);
  localparam int MW  = (MAC_BYTES > 1) ? $clog2(MAC_BYTES) : 1;

  logic [1:0]     phase_r, phase_nxt;
  logic [7:0]     names_r, names_nxt;
  logic [EPW-1:0] pos_r, pos_nxt;
  logic [15:0]    offset_r, offset_nxt;
  logic [MW-1:0]  mac_r, mac_nxt;
  logic [2:0]     kind;
  logic [7:0]     jdata;
  logic           accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [1:0]    ph;
    logic [15:0]   offs;
    logic [MW-1:0] mac_cur;
    ph         = in_record_start ? nbt_pkg::PH_COUNT : phase_r;
    offs       = in_record_start ? 16'd0 : offset_r;
    mac_cur    = mac_r;
    names_nxt  = names_r;
    pos_nxt    = pos_r;
    mac_nxt    = mac_r;
    kind       = nbt_pkg::K_NONE;
    jdata      = in_data_byte;
    offset_nxt = (offs == 16'hFFFF) ? offs : offs + 16'd1;
    if (offs >= in_record_length) begin
      ph = nbt_pkg::PH_DONE;
    end else if (ph == nbt_pkg::PH_COUNT) begin
      names_nxt = in_data_byte;
      pos_nxt   = '0;
      mac_nxt   = '0;
      ph        = nbt_pkg::PH_NAMES;
    end else begin
      if (ph == nbt_pkg::PH_NAMES && pos_r == '0 && (names_r == 8'd0 ||
          ({1'b0, offs} + 17'(ENTRY_BYTES)) > {1'b0, in_record_length})) begin
        ph      = nbt_pkg::PH_MAC;
        mac_cur = '0;
        mac_nxt = '0;
      end
      if (ph == nbt_pkg::PH_NAMES) begin
        if (pos_r < EPW'(NAME_CHARS)) begin
          if (in_data_byte == 8'h20 || in_data_byte == 8'h00) begin
            kind  = nbt_pkg::K_CHAR;
            jdata = nbt_pkg::CH_SPACE;
          end else if (in_data_byte >= 8'h21 && in_data_byte <= 8'h7E) begin
            kind = nbt_pkg::K_CHAR;
          end else begin
            kind = nbt_pkg::K_HEX;
          end
        end else if (pos_r == EPW'(NAME_CHARS)) begin
          kind = nbt_pkg::K_SUFFIX;
        end
        if (pos_r == EPW'(ENTRY_BYTES - 1)) begin
          pos_nxt   = '0;
          names_nxt = names_r - 8'd1;
        end else begin
          pos_nxt = pos_r + EPW'(1);
        end
      end else if (ph == nbt_pkg::PH_MAC) begin
        if (mac_cur == MW'(MAC_BYTES - 1)) begin
          kind = nbt_pkg::K_MAC_END;
          ph   = nbt_pkg::PH_DONE;
        end else begin
          kind    = nbt_pkg::K_MAC_SEP;
          mac_nxt = mac_cur + MW'(1);
        end
      end
    end
    if (in_record_last) begin
      ph         = nbt_pkg::PH_COUNT;
      offset_nxt = 16'd0;
    end
    phase_nxt = ph;
  end

  assign push          = accept && (kind != nbt_pkg::K_NONE || in_record_last);
  assign push_job.kind = (kind == nbt_pkg::K_NONE) ? nbt_pkg::K_BARE : kind;
  assign push_job.data = jdata;
  assign push_job.last = in_record_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= nbt_pkg::PH_COUNT;
      names_r  <= 8'd0;
      pos_r    <= '0;
      offset_r <= 16'd0;
      mac_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      names_r  <= names_nxt;
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
      mac_r    <= mac_nxt;
    end
  end

endmodule

/* rtl/nbt_queue.sv */
// ----------------------------------------------------------------------------
// nbt_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module nbt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nbt_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output nbt_pkg::job_t head_job
);

  nbt_pkg::job_t            mem_r [nbt_pkg::QDEPTH];
  logic [nbt_pkg::QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [nbt_pkg::QAW:0]    count_r, count_nxt;

  assign full       = (count_r == (nbt_pkg::QAW + 1)'(nbt_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");
`endif

endmodule

/* rtl/nbt_back.sv */
// ----------------------------------------------------------------------------
// nbt_back
// Expands queued jobs into characters, one per cycle while the output is ready, through an output register.
// ----------------------------------------------------------------------------
module nbt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  nbt_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_text_char,
  output logic          out_char_valid,
  output logic          out_banner_end
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] char_r;
  logic       cvalid_r;
  logic       bend_r;
  logic       load;
  logic       last_char;

  assign last_char = (idx_r == nbt_pkg::job_len(head_job.kind) - 3'd1);
  assign load      = head_valid && (!out_valid_r || out_ready);
  assign pop       = load && last_char;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_char ? 3'd0 : idx_r + 3'd1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r   <= nbt_pkg::job_char(head_job.kind, head_job.data, idx_r);
      cvalid_r <= (head_job.kind != nbt_pkg::K_BARE);
      bend_r   <= head_job.last && last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_text_char  = char_r;
  assign out_char_valid = cvalid_r;
  assign out_banner_end = bend_r;

`ifndef SYNTH
  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !cvalid_r) |-> bend_r) else $error("bare item without end flag");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r < nbt_pkg::job_len(head_job.kind)))
    else $error("character index beyond job length");
`endif

endmodule

/* rtl/nbtstat_record_to_text.sv */
// ----------------------------------------------------------------------------
// nbtstat_record_to_text
// Decodes NetBIOS node-status answer record bytes into banner text.
// ----------------------------------------------------------------------------
// One record byte is taken per item whenever the four-entry job queue has room;
// each byte yields zero to five characters, and the last byte of a record
// always yields at least one result carrying banner_end. The character stage
// emits one result per cycle while a job is queued and the output is ready.
// A name suffix byte yields five characters, a hex-escaped name byte four and
// a MAC byte followed by a dash three. An accepted byte passes through the job
// queue and the output register before its first character is shown.
module nbtstat_record_to_text #(
  parameter int NAME_CHARS  = 15,
  parameter int ENTRY_BYTES = 18,
  parameter int MAC_BYTES   = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_record_start,
  input  logic        in_record_last,
  input  logic [15:0] in_record_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_text_char,
  output logic        out_char_valid,
  output logic        out_banner_end
);

  logic          q_full;
  logic          push;
  nbt_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  nbt_pkg::job_t head_job;

  nbt_front #(
    .NAME_CHARS  (NAME_CHARS),
    .ENTRY_BYTES (ENTRY_BYTES),
    .MAC_BYTES   (MAC_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_record_start  (in_record_start),
    .in_record_last   (in_record_last),
    .in_record_length (in_record_length),
    .q_full           (q_full),
    .push             (push),
    .push_job         (push_job)
  );

  nbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  nbt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_text_char  (out_text_char),
    .out_char_valid (out_char_valid),
    .out_banner_end (out_banner_end)
  );

endmodule

/* tb/sv/nbtstat_text_checker.sv */
// ----------------------------------------------------------------------------
// nbtstat_text_checker
// Watches both channels of the node-status decoder. Every accepted record byte
// runs through a local model of the decoder, and the characters it should
// cause are queued. Every accepted output character is compared field by field
// against the oldest queued one. Mismatches and unexpected characters are
// counted. The number of characters still owed is reported to the top.
// ----------------------------------------------------------------------------
module nbtstat_text_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_record_start,
  input  logic        in_record_last,
  input  logic [15:0] in_record_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_text_char,
  input  logic        out_char_valid,
  input  logic        out_banner_end,
  output int          fail_count,
  output int          pending
);

  localparam int NAME_CHARS  = 15;
  localparam int ENTRY_BYTES = 18;
  localparam int MAC_BYTES   = 6;
  localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

  typedef struct packed {
    logic [7:0] text_char;
    logic       char_valid;
    logic       banner_end;
  } banner_char_t;

  banner_char_t banner_q[$];

  logic [1:0]  dec_phase;
  logic [7:0]  names_left;
  logic [4:0]  entry_pos;
  logic [15:0] byte_off;
  logic [2:0]  mac_idx;

  logic [7:0]  step_chars[6];
  int          step_n;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic add_char(input logic [7:0] ch);
    step_chars[step_n] = ch;
    step_n++;
  endtask

  task automatic add_hex(input logic [7:0] b);
    add_char(HEX_DIGITS[8 * (15 - int'(b[7:4])) +: 8]);
    add_char(HEX_DIGITS[8 * (15 - int'(b[3:0])) +: 8]);
  endtask

  task automatic predict_banner(input logic [7:0] b, input logic st, input logic lst,
                                input logic [15:0] len);
    int           offs;
    int           pos;
    banner_char_t c;
    begin
      step_n = 0;
      if (st) begin
        dec_phase = nbt_pkg::PH_COUNT;
        byte_off  = '0;
      end
      offs = int'(byte_off);
      if (byte_off != 16'hFFFF) begin
        byte_off = byte_off + 16'd1;
      end

      if (offs >= int'(len)) begin
        dec_phase = nbt_pkg::PH_DONE;
      end else if (dec_phase == nbt_pkg::PH_COUNT) begin
        names_left = b;
        entry_pos  = '0;
        mac_idx    = '0;
        dec_phase  = nbt_pkg::PH_NAMES;
      end else begin
        if (dec_phase == nbt_pkg::PH_NAMES && entry_pos == 5'd0 &&
            (names_left == 8'd0 || offs + ENTRY_BYTES > int'(len))) begin
          dec_phase = nbt_pkg::PH_MAC;
          mac_idx   = '0;
        end
        if (dec_phase == nbt_pkg::PH_NAMES) begin
          pos = int'(entry_pos);
          if (pos < NAME_CHARS) begin
            if (b == nbt_pkg::CH_SPACE || b == 8'h00) begin
              add_char(nbt_pkg::CH_SPACE);
            end else if (b >= 8'h21 && b <= 8'h7E) begin
              add_char(b);
            end else begin
              add_char(nbt_pkg::CH_LT);
              add_hex(b);
              add_char(nbt_pkg::CH_GT);
            end
          end else if (pos == NAME_CHARS) begin
            add_char(nbt_pkg::CH_LT);
            add_hex(b);
            add_char(nbt_pkg::CH_GT);
            add_char(nbt_pkg::CH_NL);
          end
          if (pos + 1 >= ENTRY_BYTES) begin
            entry_pos  = '0;
            names_left = names_left - 8'd1;
          end else begin
            entry_pos = 5'(pos + 1);
          end
        end else if (dec_phase == nbt_pkg::PH_MAC) begin
          add_hex(b);
          if (int'(mac_idx) + 1 < MAC_BYTES) begin
            add_char(nbt_pkg::CH_DASH);
            mac_idx = mac_idx + 3'd1;
          end else begin
            dec_phase = nbt_pkg::PH_DONE;
          end
        end
      end

      if (step_n == 0 && lst) begin
        c.text_char  = 8'h00;
        c.char_valid = 1'b0;
        c.banner_end = 1'b1;
        banner_q.push_back(c);
      end
      for (int i = 0; i < step_n; i++) begin
        c.text_char  = step_chars[i];
        c.char_valid = 1'b1;
        c.banner_end = lst && (i == step_n - 1);
        banner_q.push_back(c);
      end
      if (lst) begin
        dec_phase = nbt_pkg::PH_COUNT;
        byte_off  = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    banner_char_t want;
    if (!rst_n) begin
      dec_phase  = nbt_pkg::PH_COUNT;
      names_left = '0;
      entry_pos  = '0;
      byte_off   = '0;
      mac_idx    = '0;
      banner_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_banner(in_data_byte, in_record_start, in_record_last, in_record_length);
      end
      if (out_valid && out_ready) begin
        if (banner_q.size() == 0) begin
          $error("unexpected item: text_char %02h char_valid %0b banner_end %0b",
                 out_text_char, out_char_valid, out_banner_end);
          fail_count++;
        end else begin
          want = banner_q.pop_front();
          if (out_text_char !== want.text_char) begin
            $error("text_char: expected %02h, got %02h", want.text_char, out_text_char);
            fail_count++;
          end
          if (out_char_valid !== want.char_valid) begin
            $error("char_valid: expected %0b, got %0b", want.char_valid, out_char_valid);
            fail_count++;
          end
          if (out_banner_end !== want.banner_end) begin
            $error("banner_end: expected %0b, got %0b", want.banner_end, out_banner_end);
            fail_count++;
          end
        end
      end
    end
    pending = banner_q.size();
  end

endmodule

/* tb/sv/nbtstat_record_to_text_tb.sv */
// ----------------------------------------------------------------------------
// nbtstat_record_to_text_tb
// Drives node-status answer records into the decoder: a directed set covering
// name escapes, suffix, MAC text, truncated and short records, then random
// well-formed, broken and noise records with random idling on both sides, a
// long output stall and a full drain. The checker predicts and compares.
// ----------------------------------------------------------------------------
module nbtstat_record_to_text_tb;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_ITEMS   = 265;
  localparam int IDLE_PCT       = 26;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES    = 20;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        last;
    logic [15:0] len;
  } rec_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_record_start;
  logic        in_record_last;
  logic [15:0] in_record_length;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_text_char;
  logic        out_char_valid;
  logic        out_banner_end;

  int          fail_count;
  int          pending;
  int          items_sent;
  int          cycles;
  bit          no_idle;
  bit          rx_hold_req;
  rec_byte_t   rec_q[$];

  nbtstat_record_to_text uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_record_start  (in_record_start),
    .in_record_last   (in_record_last),
    .in_record_length (in_record_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_text_char    (out_text_char),
    .out_char_valid   (out_char_valid),
    .out_banner_end   (out_banner_end)
  );

  nbtstat_text_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_record_start  (in_record_start),
    .in_record_last   (in_record_last),
    .in_record_length (in_record_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_text_char    (out_text_char),
    .out_char_valid   (out_char_valid),
    .out_banner_end   (out_banner_end),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** nbtstat_record_to_text: FAILED **");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic st, input logic lst,
                           input logic [15:0] len);
    logic acc;
    begin
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid         <= 1'b1;
      in_data_byte     <= b;
      in_record_start  <= st;
      in_record_last   <= lst;
      in_record_length <= len;
      do begin
        @(negedge clk);
        acc = in_ready;
        @(posedge clk);
      end while (!acc);
      items_sent++;
    end
  endtask

  task automatic drain_text;
    begin
      in_valid <= 1'b0;
      do @(negedge clk); while (pending != 0);
      @(posedge clk);
    end
  endtask

  task automatic send_rec_q;
    rec_byte_t r;
    begin
      while (rec_q.size() > 0) begin
        r = rec_q.pop_front();
        send_item(r.data, r.start, r.last, r.len);
      end
    end
  endtask

  task automatic build_record(input bit broken);
    int          n_ent;
    int          n_mac;
    int          total;
    int          mode;
    int          flaw;
    int          i;
    logic [7:0]  cnt;
    logic [7:0]  b;
    logic [15:0] len;
    rec_byte_t   r;
    begin
      n_ent = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
      mode  = $urandom_range(0, 9);
      if (mode < 6) begin
        cnt = 8'(n_ent);
      end else if (mode < 8) begin
        cnt = 8'($urandom_range(0, n_ent));
      end else begin
        cnt = 8'($urandom_range(0, 255));
      end
      n_mac = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 6;
      total = 1 + n_ent * 18 + n_mac + $urandom_range(0, 3);
      mode  = $urandom_range(0, 99);
      if (mode < 80) begin
        len = 16'(total);
      end else if (mode < 90) begin
        len = 16'($urandom_range(1, total));
      end else if (mode < 95) begin
        len = 16'(total + $urandom_range(1, 40));
      end else begin
        len = 16'hFFFF;
      end
      flaw = broken ? $urandom_range(1, 3) : 0;
      for (i = 0; i < total; i++) begin
        if (i == 0) begin
          b = cnt;
        end else if (i <= n_ent * 18 && ((i - 1) % 18) < 15) begin
          case ($urandom_range(0, 5))
            0:       b = 8'h00;
            1:       b = 8'h20;
            2, 3:    b = 8'($urandom_range(8'h21, 8'h7E));
            4:       b = 8'($urandom_range(8'h7F, 8'hFF));
            default: b = 8'($urandom);
          endcase
        end else begin
          b = 8'($urandom);
        end
        r.data  = b;
        r.start = (i == 0) && (flaw != 1);
        r.last  = (i == total - 1) && (flaw != 2);
        r.len   = (flaw == 3) ? 16'($urandom_range(1, total + 4)) : len;
        rec_q.push_back(r);
      end
    end
  endtask

  initial begin
    logic [7:0] dir_name[15];
    int         rnd_base;
    int         k;
    int         n;
    int         kind;
    bit         hold_done;
    bit         pause_done;
    rec_byte_t  r;

    dir_name = '{8'h00, 8'h20, 8'h21, 8'h7E, 8'h1F, 8'h7F, 8'h80, 8'hFF,
                 8'h41, 8'h7A, 8'h01, 8'h5C, 8'h30, 8'h39, 8'hC3};
    no_idle          = 1'b0;
    rx_hold_req      = 1'b0;
    hold_done        = 1'b0;
    pause_done       = 1'b0;
    items_sent       = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_data_byte     <= 8'h00;
    in_record_start  <= 1'b0;
    in_record_last   <= 1'b0;
    in_record_length <= 16'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // full entry, count byte taken without a record start
    send_item(8'd1, 1'b0, 1'b0, 16'd25);
    foreach (dir_name[i]) send_item(dir_name[i], 1'b0, 1'b0, 16'd25);
    send_item(8'h20, 1'b0, 1'b0, 16'd25);
    send_item(8'h04, 1'b0, 1'b0, 16'd25);
    send_item(8'h00, 1'b0, 1'b0, 16'd25);
    send_item(8'h00, 1'b0, 1'b0, 16'd25);
    send_item(8'hFF, 1'b0, 1'b0, 16'd25);
    send_item(8'h12, 1'b0, 1'b0, 16'd25);
    send_item(8'hAB, 1'b0, 1'b0, 16'd25);
    send_item(8'h5A, 1'b0, 1'b0, 16'd25);
    send_item(8'hA5, 1'b0, 1'b1, 16'd25);
    drain_text;

    // no names, byte past the length, bare end marker
    send_item(8'h00, 1'b1, 1'b0, 16'd3);
    send_item(8'h11, 1'b0, 1'b0, 16'd3);
    send_item(8'h22, 1'b0, 1'b0, 16'd3);
    send_item(8'h33, 1'b0, 1'b1, 16'd3);

    // entry does not fit, bytes after the MAC, length changing mid record
    send_item(8'h03, 1'b1, 1'b0, 16'd10);
    send_item(8'hFE, 1'b0, 1'b0, 16'd10);
    send_item(8'h01, 1'b0, 1'b0, 16'd10);
    send_item(8'h9C, 1'b0, 1'b0, 16'hFFFF);
    send_item(8'hC9, 1'b0, 1'b0, 16'd10);
    send_item(8'h7E, 1'b0, 1'b0, 16'd10);
    send_item(8'h0F, 1'b0, 1'b0, 16'd10);
    send_item(8'h55, 1'b0, 1'b0, 16'hFFFF);
    send_item(8'hAA, 1'b0, 1'b1, 16'd10);

    // one-byte record
    send_item(8'hFF, 1'b1, 1'b1, 16'd1);
    drain_text;

    rnd_base = items_sent;
    while (items_sent - rnd_base < RANDOM_ITEMS) begin
      k = items_sent - rnd_base;
      no_idle = (k >= 180 && k < 250);
      if (!hold_done && k >= 60) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
      end
      if (!pause_done && k >= 160) begin
        pause_done = 1'b1;
        drain_text;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_record(1'b0);
      end else if (kind < 85) begin
        build_record(1'b1);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          r.data  = 8'($urandom);
          r.start = ($urandom_range(0, 3) == 0);
          r.last  = ($urandom_range(0, 3) == 0);
          r.len   = 16'($urandom_range(1, 65535));
          rec_q.push_back(r);
        end
      end
      send_rec_q;
    end
    no_idle = 1'b0;

    drain_text;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** nbtstat_record_to_text: PASSED **");
    end else begin
      $display("** nbtstat_record_to_text: FAILED **");
    end
    $finish;
  end

endmodule
